// ===== src/pps_pkg.sv =====
// Package for the pulsed pump preheat sequencer.
// Holds shared codes, state encodings, command/status structs and constants.
// No dependencies.
package pps_pkg;

	localparam int TABLE_STEPS_DEF = 5;
	localparam int MS_PER_S        = 1000;
	localparam int OFF_SCALE_DIV   = 5;
	localparam int PCT_FULL        = 100;

	// shared divider: 26-bit dividend, 8-bit divisor, two quotient bits a step
	localparam int DIV_W      = 26;
	localparam int DVS_W      = 8;
	localparam int DIV_STEPS  = DIV_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	// stream payload widths
	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	localparam int CFG_IDX_W  = 3;

	// register reset values
	localparam logic        RST_ENABLE   = 1'b1;
	localparam logic [31:0] RST_TIMEOUT  = 32'd600000;
	localparam logic [7:0]  RST_MAX_CYC  = 8'd10;
	localparam logic [15:0] RST_PUMP_MIN = 16'd5000;
	localparam logic [15:0] RST_SAFE     = 16'd300;
	localparam logic [7:0]  RST_OFF_MULT = 8'd5;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_RUN     = 2'd1,
		PH_DONE    = 2'd2,
		PH_TIMEOUT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE   = 3'd0,
		CFG_TIMEOUT  = 3'd1,
		CFG_MAX_CYC  = 3'd2,
		CFG_PUMP_MIN = 3'd3,
		CFG_SAFE     = 3'd4,
		CFG_OFF_MULT = 3'd5,
		CFG_ON_TBL   = 3'd6,
		CFG_OFF_TBL  = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TBL,
		S_MUL,
		S_DIVO,
		S_APPLY,
		S_PMUL,
		S_DIVP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load_in;   // capture the input word
		logic tbl;       // look up on time and off product
		logic div_start; // load the shared divider
		logic div_prog;  // divider operands: 1 progress, 0 off time
		logic div_step;  // run one divider step
		logic apply;     // commit the state update
		logic out_load;  // fill the result register
	} cmd_t;

	typedef struct packed {
		logic div_last;  // divider finishes on this step
	} st_t;

endpackage

// ===== src/pps_ctrl.sv =====
// Sequencing state machine for the preheat sequencer.
// Drives datapath commands and both stream handshakes; uses pps_pkg.
module pps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pps_pkg::st_t  st,
	output pps_pkg::cmd_t cmd
);

	pps_pkg::state_t state_q;
	pps_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pps_pkg::S_IDLE:  if (in_valid) state_nxt = pps_pkg::S_TBL;
			pps_pkg::S_TBL:   state_nxt = pps_pkg::S_MUL;
			pps_pkg::S_MUL:   state_nxt = pps_pkg::S_DIVO;
			pps_pkg::S_DIVO:  if (st.div_last) state_nxt = pps_pkg::S_APPLY;
			pps_pkg::S_APPLY: state_nxt = pps_pkg::S_PMUL;
			pps_pkg::S_PMUL:  state_nxt = pps_pkg::S_DIVP;
			pps_pkg::S_DIVP:  if (st.div_last) state_nxt = pps_pkg::S_OUT;
			pps_pkg::S_OUT:   if (slot_free) state_nxt = pps_pkg::S_IDLE;
			default:          state_nxt = pps_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pps_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			pps_pkg::S_TBL:   cmd.tbl = 1'b1;
			pps_pkg::S_MUL:   cmd.div_start = 1'b1;
			pps_pkg::S_DIVO:  cmd.div_step = 1'b1;
			pps_pkg::S_APPLY: cmd.apply = 1'b1;
			pps_pkg::S_PMUL: begin
				cmd.div_start = 1'b1;
				cmd.div_prog  = 1'b1;
			end
			pps_pkg::S_DIVP:  cmd.div_step = 1'b1;
			pps_pkg::S_OUT:   cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pps_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// hold the result word until taken; a new load overrides the drop
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/pps_dp.sv =====
// Datapath of the preheat sequencer: configuration, run state, table lookup,
// shared serial divider and result register. Uses pps_pkg; driven by pps_ctrl.
module pps_dp #(
	parameter int TABLE_STEPS = pps_pkg::TABLE_STEPS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [((8*TABLE_STEPS > 32) ? 8*TABLE_STEPS : 32)-1:0] cfg_wdata,
	input  logic [pps_pkg::IN_DATA_W-1:0]             in_data,
	input  logic [pps_pkg::IN_USER_W-1:0]             in_user,
	input  pps_pkg::cmd_t                             cmd,
	output pps_pkg::st_t                              st,
	output logic [pps_pkg::OUT_DATA_W-1:0]            out_data
);

	localparam int IDX_W = $clog2(TABLE_STEPS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_STEPS - 1);

	// configuration
	logic                        enable_q;
	logic [31:0]                 timeout_q;
	logic [7:0]                  max_cyc_q;
	logic [15:0]                 pump_min_q;
	logic signed [15:0]          safe_q;
	logic [7:0]                  off_mult_q;
	logic [TABLE_STEPS-1:0][7:0] on_tbl_q;
	logic [TABLE_STEPS-1:0][7:0] off_tbl_q;

	// run state
	pps_pkg::phase_t phase_q;
	logic [7:0]      cycle_q;
	logic            pump_q;
	logic [31:0]     pst_q;
	logic [31:0]     cst_q;
	logic [31:0]     lct_q;
	logic            acc_q;

	// captured input word
	pps_pkg::op_t       op_q;
	logic [31:0]        now_q;
	logic signed [15:0] sup_q;
	logic signed [15:0] ret_q;
	logic               sv_q;
	logic               rv_q;

	logic [15:0] on_ms_q;
	logic [15:0] prod_s1;

	// divider
	logic [pps_pkg::DVS_W-1:0]     rem_q;
	logic [pps_pkg::DIV_W-1:0]     quo_q;
	logic [pps_pkg::DVS_W-1:0]     dvs_q;
	logic [pps_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pps_pkg::DVS_W-1:0]     rem_nxt;
	logic [pps_pkg::DIV_W-1:0]     quo_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= pps_pkg::RST_ENABLE;
			timeout_q  <= pps_pkg::RST_TIMEOUT;
			max_cyc_q  <= pps_pkg::RST_MAX_CYC;
			pump_min_q <= pps_pkg::RST_PUMP_MIN;
			safe_q     <= pps_pkg::RST_SAFE;
			off_mult_q <= pps_pkg::RST_OFF_MULT;
			on_tbl_q   <= '0;
			off_tbl_q  <= '0;
		end else if (cfg_we) begin
			unique case (pps_pkg::cfg_idx_t'(cfg_index))
				pps_pkg::CFG_ENABLE:   enable_q   <= cfg_wdata[0];
				pps_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_wdata[31:0];
				pps_pkg::CFG_MAX_CYC:  max_cyc_q  <= cfg_wdata[7:0];
				pps_pkg::CFG_PUMP_MIN: pump_min_q <= cfg_wdata[15:0];
				pps_pkg::CFG_SAFE:     safe_q     <= cfg_wdata[15:0];
				pps_pkg::CFG_OFF_MULT: off_mult_q <= cfg_wdata[7:0];
				pps_pkg::CFG_ON_TBL:   on_tbl_q   <= cfg_wdata[8*TABLE_STEPS-1:0];
				pps_pkg::CFG_OFF_TBL:  off_tbl_q  <= cfg_wdata[8*TABLE_STEPS-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= pps_pkg::op_t'(in_user);
			now_q <= in_data[31:0];
			sup_q <= in_data[47:32];
			ret_q <= in_data[63:48];
			sv_q  <= in_data[64];
			rv_q  <= in_data[65];
		end
	end

	// table lookup: cycles one to TABLE_STEPS-1 have own bytes, the last byte
	// serves later cycles and cycle zero
	logic [IDX_W-1:0] tbl_idx;
	logic [7:0]       on_byte;
	logic [7:0]       off_byte;

	always_comb begin
		if (cycle_q >= 8'd1 && cycle_q < TABLE_STEPS) tbl_idx = IDX_W'(cycle_q - 8'd1);
		else tbl_idx = LAST_IDX;
		on_byte  = on_tbl_q[tbl_idx];
		off_byte = off_tbl_q[tbl_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl) begin
			on_ms_q <= 16'(on_byte * 10'(pps_pkg::MS_PER_S));
			prod_s1 <= off_byte * off_mult_q;
		end
	end

	// shared restoring divider, two quotient bits a cycle
	always_comb begin
		logic [pps_pkg::DVS_W:0] t;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int i = 0; i < 2; i++) begin
			t       = {rem_nxt, quo_nxt[pps_pkg::DIV_W-1]};
			quo_nxt = {quo_nxt[pps_pkg::DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t          = t - {1'b0, dvs_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = t[pps_pkg::DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= pps_pkg::DIV_CNT_W'(pps_pkg::DIV_STEPS);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			if (cmd.div_prog) begin
				dvs_q <= max_cyc_q;
				quo_q <= pps_pkg::DIV_W'(cycle_q * 7'(pps_pkg::PCT_FULL));
			end else begin
				dvs_q <= pps_pkg::DVS_W'(pps_pkg::OFF_SCALE_DIV);
				quo_q <= pps_pkg::DIV_W'(prod_s1 * 10'(pps_pkg::MS_PER_S));
			end
		end else if (cmd.div_step) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	assign st.div_last = (cnt_q == pps_pkg::DIV_CNT_W'(1));

	// state update
	logic signed [16:0] diff_w;
	logic signed [15:0] diff_sat;
	logic               safe;
	logic [31:0]        elapsed;
	logic               gap_ok;
	logic               tmo_hit;
	logic [7:0]         cyc_inc;

	pps_pkg::phase_t phase_nxt;
	logic [7:0]      cycle_nxt;
	logic            pump_nxt;
	logic [31:0]     pst_nxt;
	logic [31:0]     cst_nxt;
	logic [31:0]     lct_nxt;
	logic            acc_nxt;

	always_comb begin
		diff_w = {sup_q[15], sup_q} - {ret_q[15], ret_q};
		if (diff_w[16] != diff_w[15]) diff_sat = diff_w[16] ? 16'sh8000 : 16'sh7FFF;
		else diff_sat = diff_w[15:0];
		safe    = sv_q && rv_q && (diff_sat < safe_q);
		elapsed = now_q - cst_q;
		gap_ok  = (now_q - lct_q) >= {16'd0, pump_min_q};
		tmo_hit = (now_q - pst_q) > timeout_q;
		cyc_inc = (cycle_q != 8'hFF) ? cycle_q + 8'd1 : cycle_q;

		phase_nxt = phase_q;
		cycle_nxt = cycle_q;
		pump_nxt  = pump_q;
		pst_nxt   = pst_q;
		cst_nxt   = cst_q;
		lct_nxt   = lct_q;
		acc_nxt   = 1'b1;

		unique case (op_q)
			pps_pkg::OP_UPDATE: begin
				if (phase_q == pps_pkg::PH_RUN) begin
					if (tmo_hit || cycle_q > max_cyc_q) begin
						pump_nxt  = 1'b0;
						phase_nxt = pps_pkg::PH_TIMEOUT;
					end else if (safe) begin
						pump_nxt  = 1'b0;
						phase_nxt = pps_pkg::PH_DONE;
					end else if (pump_q) begin
						if (elapsed >= {16'd0, on_ms_q} && gap_ok) begin
							pump_nxt = 1'b0;
							cst_nxt  = now_q;
							lct_nxt  = now_q;
						end
					end else if (elapsed >= {16'd0, quo_q[15:0]} && gap_ok) begin
						// past the limit: keep the pump off, next update times out
						cycle_nxt = cyc_inc;
						if (cyc_inc <= max_cyc_q) begin
							pump_nxt = 1'b1;
							cst_nxt  = now_q;
							lct_nxt  = now_q;
						end
					end
				end
			end
			pps_pkg::OP_START: begin
				if (phase_q == pps_pkg::PH_RUN) begin
					acc_nxt = 1'b0;
				end else if (!enable_q || safe) begin
					phase_nxt = pps_pkg::PH_DONE;
				end else begin
					phase_nxt = pps_pkg::PH_RUN;
					cycle_nxt = 8'd1;
					pump_nxt  = 1'b1;
					pst_nxt   = now_q;
					cst_nxt   = now_q;
					lct_nxt   = now_q;
				end
			end
			pps_pkg::OP_STOP: begin
				phase_nxt = pps_pkg::PH_IDLE;
				cycle_nxt = 8'd0;
				pump_nxt  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pps_pkg::PH_IDLE;
			cycle_q <= 8'd0;
			pump_q  <= 1'b0;
			pst_q   <= 32'd0;
			cst_q   <= 32'd0;
			lct_q   <= 32'd0;
			acc_q   <= 1'b1;
		end else if (cmd.apply) begin
			phase_q <= phase_nxt;
			cycle_q <= cycle_nxt;
			pump_q  <= pump_nxt;
			pst_q   <= pst_nxt;
			cst_q   <= cst_nxt;
			lct_q   <= lct_nxt;
			acc_q   <= acc_nxt;
		end
	end

	// result word
	logic       run;
	logic       fin;
	logic [6:0] prog;

	always_comb begin
		run = (phase_q == pps_pkg::PH_RUN);
		fin = (phase_q == pps_pkg::PH_DONE) || (phase_q == pps_pkg::PH_TIMEOUT);
		if (fin) prog = 7'(pps_pkg::PCT_FULL);
		else if (run && max_cyc_q != 8'd0) begin
			if (quo_q > pps_pkg::DIV_W'(pps_pkg::PCT_FULL)) prog = 7'(pps_pkg::PCT_FULL);
			else prog = quo_q[6:0];
		end else prog = 7'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data <= {4'd0, fin, acc_q, prog, (run ? cycle_q : 8'd0),
				(run && pump_q), phase_q};
		end
	end

endmodule

// ===== src/pulsed_pump_preheat_sequencer.sv =====
// Top level of the pulsed pump preheat sequencer.
// Joins the controller pps_ctrl and the datapath pps_dp; uses pps_pkg.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata, s_tuser (opcode)
//  m_       out        m_tvalid/m_tready  m_tdata
//  cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// From acceptance to result a word passes a table lookup, a multiply that
// loads the shared divider, two passes through the divider (off time scaling,
// then progress, each loaded by its own multiply), plus update and load steps.
// Reset is asynchronous, active low, and restores the configuration defaults and the run state.
// A result waits in the output register; the next word is accepted meanwhile
// and held only at its own load if the previous result is still not taken.
module pulsed_pump_preheat_sequencer #(
	parameter int TABLE_STEPS = pps_pkg::TABLE_STEPS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// now_ms[31:0], supply_temp[47:32], return_temp[63:48],
	// supply_valid[64], return_valid[65], zero fill
	input  logic [pps_pkg::IN_DATA_W-1:0]             s_tdata,
	// opcode[1:0]
	input  logic [pps_pkg::IN_USER_W-1:0]             s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// phase[1:0], pump_request[2], cycle_number[10:3], progress_pct[17:11],
	// accepted[18], finished[19], zero fill
	output logic [pps_pkg::OUT_DATA_W-1:0]            m_tdata,
	input  logic                                      cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [((8*TABLE_STEPS > 32) ? 8*TABLE_STEPS : 32)-1:0] cfg_wdata
);

	pps_pkg::cmd_t cmd;
	pps_pkg::st_t  st;

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.st        (st),
		.cmd       (cmd)
	);

	pps_dp #(
		.TABLE_STEPS (TABLE_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cmd       (cmd),
		.st        (st),
		.out_data  (m_tdata)
	);

endmodule

// ===== bench/tb_pulsed_pump_preheat_sequencer.sv =====
// Testbench for pulsed_pump_preheat_sequencer: a directed table, then random pump runs
// under several register settings, with an in-bench status predictor checking each word.
// Depends on pps_pkg and the sequencer RTL only.
module tb_pulsed_pump_preheat_sequencer;
	import pps_pkg::*;

	localparam int STEPS         = TABLE_STEPS_DEF;
	localparam int TBL_W         = 8 * STEPS;
	localparam int CFG_W         = (TBL_W > 32) ? TBL_W : 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int RUN_LIMIT     = 600000;
	localparam int REPORT_MAX    = 10;
	localparam int PHASES        = 9;

	typedef struct packed {
		logic       finished;
		logic       accepted;
		logic [6:0] pct;
		logic [7:0] cycle;
		logic       pump;
		phase_t     phase;
	} status_t;

	typedef struct {
		op_t                op;
		logic [31:0]        now;
		logic signed [15:0] sup;
		logic signed [15:0] ret;
		logic               sv;
		logic               rv;
		logic               fixed_on;
		status_t            fixed;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [IN_USER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// register copies held by the predictor
	logic               cf_enable;
	logic [31:0]        cf_timeout;
	logic [7:0]         cf_maxcyc;
	logic [15:0]        cf_pump_min;
	logic signed [15:0] cf_safe;
	logic [7:0]         cf_mult;
	logic [TBL_W-1:0]   cf_on_tbl;
	logic [TBL_W-1:0]   cf_off_tbl;

	// sequencer state held by the predictor
	phase_t      pr_phase;
	logic [7:0]  pr_cycles;
	logic        pr_pump;
	logic [31:0] pr_t_start;
	logic [31:0] pr_t_cycle;
	logic [31:0] pr_t_change;

	status_t   status_due[$];
	plan_row_t plan[$];
	status_t   seen;
	status_t   due;

	bit          idle_on = 1'b1;
	int          gap_pct = 30;
	int          stall_pct = 15;
	int          stall_left = 0;
	int          step_max;
	int          quota;
	int          live_items;
	logic [31:0] clock_ms;
	int          cycles_run = 0;
	int          words_sent = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          done_seen = 0;
	int          timeout_seen = 0;
	int          refused_seen = 0;
	int          top_cycle = 0;

	pulsed_pump_preheat_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] table_sec(logic [TBL_W-1:0] tbl, logic [7:0] cyc);
		int idx;
		idx = STEPS - 1;
		if (cyc >= 1 && cyc < STEPS)
			idx = cyc - 1;
		return tbl[8*idx +: 8];
	endfunction

	function automatic logic [15:0] on_ms(logic [7:0] cyc);
		logic [31:0] p;
		p = 32'(table_sec(cf_on_tbl, cyc)) * 32'(MS_PER_S);
		return p[15:0];
	endfunction

	function automatic logic [15:0] off_ms(logic [7:0] cyc);
		logic [31:0] p;
		p = 32'(table_sec(cf_off_tbl, cyc)) * 32'(MS_PER_S) * 32'(cf_mult);
		p = p / 32'(OFF_SCALE_DIV);
		return p[15:0];
	endfunction

	function automatic bit temps_safe(logic signed [15:0] sup, ret, logic sv, rv);
		int d;
		if (!(sv && rv))
			return 1'b0;
		d = int'(sup) - int'(ret);
		if (d > 32767)
			d = 32767;
		if (d < -32768)
			d = -32768;
		return d < int'(cf_safe);
	endfunction

	function automatic status_t mk_status(phase_t ph, logic pump, logic [7:0] cyc,
			logic [6:0] pct, logic acc, logic fin);
		status_t s;
		s.phase = ph;
		s.pump = pump;
		s.cycle = cyc;
		s.pct = pct;
		s.accepted = acc;
		s.finished = fin;
		return s;
	endfunction

	// advance the predicted state by one word and return the status it reports
	function automatic status_t predict_status(op_t op, logic [31:0] now,
			logic signed [15:0] sup, ret, logic sv, rv);
		status_t s;
		logic acc;
		int pct;
		bit safe;
		bit run;
		logic [31:0] since_start, since_cycle, since_change;
		acc = 1'b1;
		pct = 0;
		safe = temps_safe(sup, ret, sv, rv);
		since_start = now - pr_t_start;
		since_cycle = now - pr_t_cycle;
		since_change = now - pr_t_change;
		case (op)
			OP_UPDATE: begin
				if (pr_phase == PH_RUN) begin
					if (since_start > cf_timeout || pr_cycles > cf_maxcyc) begin
						pr_pump = 1'b0;
						pr_phase = PH_TIMEOUT;
					end else if (safe) begin
						pr_pump = 1'b0;
						pr_phase = PH_DONE;
					end else if (pr_pump) begin
						if (since_cycle >= on_ms(pr_cycles) && since_change >= cf_pump_min) begin
							pr_pump = 1'b0;
							pr_t_cycle = now;
							pr_t_change = now;
						end
					end else if (since_cycle >= off_ms(pr_cycles) &&
							since_change >= cf_pump_min) begin
						if (pr_cycles != 8'hFF)
							pr_cycles = pr_cycles + 8'd1;
						// past the limit: keep the pump off, next update times out
						if (pr_cycles <= cf_maxcyc) begin
							pr_pump = 1'b1;
							pr_t_cycle = now;
							pr_t_change = now;
						end
					end
				end
			end
			OP_START: begin
				if (pr_phase == PH_RUN) begin
					acc = 1'b0;
				end else if (!cf_enable || safe) begin
					pr_phase = PH_DONE;
				end else begin
					pr_phase = PH_RUN;
					pr_cycles = 8'd1;
					pr_t_start = now;
					pr_t_cycle = now;
					pr_t_change = now;
					pr_pump = 1'b1;
				end
			end
			OP_STOP: begin
				pr_phase = PH_IDLE;
				pr_cycles = 8'd0;
				pr_pump = 1'b0;
			end
			default: ;
		endcase
		run = (pr_phase == PH_RUN);
		if (pr_phase == PH_DONE || pr_phase == PH_TIMEOUT) begin
			pct = PCT_FULL;
		end else if (run && cf_maxcyc != 0) begin
			pct = (int'(pr_cycles) * PCT_FULL) / int'(cf_maxcyc);
			if (pct > PCT_FULL)
				pct = PCT_FULL;
		end
		s.phase = pr_phase;
		s.pump = run && pr_pump;
		s.cycle = run ? pr_cycles : 8'd0;
		s.pct = pct[6:0];
		s.accepted = acc;
		s.finished = (pr_phase == PH_DONE || pr_phase == PH_TIMEOUT);
		return s;
	endfunction

	function automatic logic [TBL_W-1:0] rand_table(int hi);
		logic [TBL_W-1:0] t;
		for (int i = 0; i < STEPS; i++)
			t[8*i +: 8] = $urandom_range(0, hi);
		return t;
	endfunction

	function automatic logic [31:0] next_step(bit plain);
		int r;
		r = $urandom_range(0, 99);
		if (plain || r < 70)
			return $urandom_range(0, step_max);
		if (r < 98)
			return $urandom_range(0, 300);
		return $urandom();
	endfunction

	function automatic void add_row(op_t op, logic [31:0] now, logic signed [15:0] sup, ret,
			logic sv, rv, logic fixed_on, status_t fixed);
		plan_row_t row;
		row.op = op;
		row.now = now;
		row.sup = sup;
		row.ret = ret;
		row.sv = sv;
		row.rv = rv;
		row.fixed_on = fixed_on;
		row.fixed = fixed;
		plan.push_back(row);
	endfunction

	// unsafe picks a difference at or above the limit, safe one below it
	task automatic pick_temps(input bit want_safe, output logic signed [15:0] sup, ret);
		int r, d, s, k;
		r = $urandom_range(0, 4000);
		r = r - 2000;
		k = $urandom_range(0, 1000);
		if (want_safe)
			d = int'(cf_safe) - 1 - k;
		else
			d = int'(cf_safe) + k;
		s = r + d;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		sup = s[15:0];
		ret = r[15:0];
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			CFG_ENABLE:   cf_enable = v[0];
			CFG_TIMEOUT:  cf_timeout = v[31:0];
			CFG_MAX_CYC:  cf_maxcyc = v[7:0];
			CFG_PUMP_MIN: cf_pump_min = v[15:0];
			CFG_SAFE:     cf_safe = v[15:0];
			CFG_OFF_MULT: cf_mult = v[7:0];
			CFG_ON_TBL:   cf_on_tbl = v[TBL_W-1:0];
			CFG_OFF_TBL:  cf_off_tbl = v[TBL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_word(op_t op, logic [31:0] now, logic signed [15:0] sup, ret,
			logic sv, rv, logic fixed_on, status_t fixed);
		int gap;
		status_t predicted;
		if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, rv, sv, ret, sup, now};
		do @(posedge clk); while (!s_tready);
		if (op == OP_START || op == OP_STOP || (op == OP_UPDATE && pr_phase == PH_RUN))
			live_items++;
		predicted = predict_status(op, now, sup, ret, sv, rv);
		status_due.push_back(fixed_on ? fixed : predicted);
		words_sent++;
	endtask

	// drop valid, wait out every pending word, then give the block time to go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int k);
		logic en;
		logic [31:0] tmo;
		logic [7:0] mx, mult;
		logic [15:0] pmin;
		logic signed [15:0] safe;
		logic [TBL_W-1:0] on_t, off_t;
		en = 1'b1;
		tmo = RST_TIMEOUT;
		mx = RST_MAX_CYC;
		pmin = RST_PUMP_MIN;
		safe = RST_SAFE;
		mult = RST_OFF_MULT;
		on_t = rand_table(3);
		off_t = rand_table(3);
		step_max = 3000;
		quota = 150;
		case (k)
			0: begin
				tmo = 300000;
				mx = 8'd4;
				pmin = 16'd1000;
				mult = 8'd255;
				step_max = 4000;
			end
			1: begin
				tmo = 50000;
				mx = 8'd0;
				pmin = 16'd0;
				safe = 16'sd0;
				mult = 8'd10;
				on_t = rand_table(2);
				off_t = rand_table(2);
				step_max = 2000;
				quota = 100;
			end
			2: begin
				tmo = 32'hFFFF_FFFF;
				mx = 8'd254;
				pmin = 16'd0;
				safe = 16'sd100;
				on_t = '0;
				off_t = '0;
				step_max = 50;
				quota = 560;
			end
			3: begin
				tmo = 32'd0;
				pmin = 16'd200;
				quota = 100;
			end
			4: begin
				en = 1'b0;
				quota = 60;
			end
			5: begin
				tmo = 32'h00FF_FFFF;
				mx = 8'd6;
				pmin = 16'hFFFF;
				safe = 16'sh8000;
				mult = 8'd0;
				on_t = '1;
				off_t = '1;
				step_max = 70000;
				quota = 100;
			end
			6: begin
				tmo = 200000;
				mx = 8'd8;
				pmin = 16'd500;
				safe = 16'sh7FFF;
				mult = 8'd1;
				on_t = rand_table(255);
				off_t = rand_table(255);
				step_max = 30000;
				quota = 100;
			end
			7: begin
				en = ($urandom_range(0, 7) != 0);
				tmo = $urandom();
				mx = $urandom_range(0, 254);
				pmin = $urandom_range(0, 65535);
				safe = $urandom_range(0, 65535);
				mult = $urandom_range(0, 255);
				on_t = rand_table(255);
				off_t = rand_table(255);
				step_max = $urandom_range(100, 70000);
			end
			default: begin
				on_t = rand_table(10);
				off_t = rand_table(10);
				step_max = 8000;
				quota = 200;
			end
		endcase
		write_reg(CFG_ENABLE, CFG_W'(en));
		write_reg(CFG_TIMEOUT, CFG_W'(tmo));
		write_reg(CFG_MAX_CYC, CFG_W'(mx));
		write_reg(CFG_PUMP_MIN, CFG_W'(pmin));
		write_reg(CFG_SAFE, CFG_W'($unsigned(safe)));
		write_reg(CFG_OFF_MULT, CFG_W'(mult));
		write_reg(CFG_ON_TBL, CFG_W'(on_t));
		write_reg(CFG_OFF_TBL, CFG_W'(off_t));
		cfg_we <= 1'b0;
	endtask

	// one pump run: start, a stream of updates with stray commands, maybe a stop; at times one random word instead
	task automatic run_sequence(int len, bit plain);
		int k, r;
		op_t op;
		logic signed [15:0] sup, ret;
		logic sv, rv;
		r = $urandom_range(0, 2);
		gap_pct = (r == 0) ? 0 : (r == 1) ? 15 : 50;
		if (!plain && $urandom_range(0, 9) == 0) begin
			op = op_t'($urandom_range(0, 3));
			send_word(op, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1),
				$urandom_range(0, 1), 1'b0, '0);
			return;
		end
		pick_temps(1'b0, sup, ret);
		clock_ms += next_step(plain);
		send_word(OP_START, clock_ms, sup, ret, 1'b1, 1'b1, 1'b0, '0);
		for (k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			op = OP_UPDATE;
			if (!plain) begin
				if (r < 4)
					op = OP_START;
				else if (r < 7)
					op = OP_NOP;
				else if (r < 9)
					op = OP_STOP;
			end
			r = $urandom_range(0, 99);
			pick_temps(!plain && r < 8, sup, ret);
			sv = 1'b1;
			rv = 1'b1;
			if (!plain && r >= 92) begin
				sv = $urandom_range(0, 1);
				rv = $urandom_range(0, 1);
			end
			clock_ms += next_step(plain);
			send_word(op, clock_ms, sup, ret, sv, rv, 1'b0, '0);
		end
		if (!plain && $urandom_range(0, 1) == 1) begin
			clock_ms += next_step(plain);
			send_word(OP_STOP, clock_ms, sup, ret, 1'b1, 1'b1, 1'b0, '0);
		end
	endtask

	// receiver stalls in bursts, at a rate that drifts over the run
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
		if ($urandom_range(0, 255) == 0)
			stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 15 : 40);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = status_t'(m_tdata[$bits(status_t)-1:0]);
			results_seen++;
			if (seen.phase == PH_DONE)
				done_seen++;
			if (seen.phase == PH_TIMEOUT)
				timeout_seen++;
			if (seen.accepted == 1'b0)
				refused_seen++;
			if (int'(seen.cycle) > top_cycle)
				top_cycle = seen.cycle;
			if (status_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected status word %h", m_tdata);
			end else begin
				due = status_due.pop_front();
				if (seen.phase !== due.phase || seen.pump !== due.pump ||
						seen.cycle !== due.cycle || seen.pct !== due.pct ||
						seen.accepted !== due.accepted || seen.finished !== due.finished) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"status mismatch: want phase=%0d pump=%0d cycle=%0d pct=%0d",
							" acc=%0d fin=%0d, got phase=%0d pump=%0d cycle=%0d pct=%0d",
							" acc=%0d fin=%0d"},
							due.phase, due.pump, due.cycle, due.pct, due.accepted,
							due.finished, seen.phase, seen.pump, seen.cycle, seen.pct,
							seen.accepted, seen.finished);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run > RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_UPDATE;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ENABLE;
		cfg_wdata <= '0;
		cf_enable = RST_ENABLE;
		cf_timeout = RST_TIMEOUT;
		cf_maxcyc = RST_MAX_CYC;
		cf_pump_min = RST_PUMP_MIN;
		cf_safe = RST_SAFE;
		cf_mult = RST_OFF_MULT;
		cf_on_tbl = '0;
		cf_off_tbl = '0;
		pr_phase = PH_IDLE;
		pr_cycles = 8'd0;
		pr_pump = 1'b0;
		pr_t_start = '0;
		pr_t_cycle = '0;
		pr_t_change = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero tables, 5 s between pump changes, limit 300, pump cycle limit RST_MAX_CYC
		add_row(OP_UPDATE, 32'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1,
			mk_status(PH_IDLE, 1'b0, 8'd0, 7'd0, 1'b1, 1'b0));
		add_row(OP_NOP, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 1'b1,
			mk_status(PH_IDLE, 1'b0, 8'd0, 7'd0, 1'b1, 1'b0));
		add_row(OP_STOP, 32'd500, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1,
			mk_status(PH_IDLE, 1'b0, 8'd0, 7'd0, 1'b1, 1'b0));
		add_row(OP_START, 32'd1000, 16'sd500, 16'sd100, 1'b1, 1'b1, 1'b1,
			mk_status(PH_RUN, 1'b1, 8'd1, 7'd10, 1'b1, 1'b0));
		add_row(OP_START, 32'd1500, 16'sd500, 16'sd100, 1'b1, 1'b1, 1'b1,
			mk_status(PH_RUN, 1'b1, 8'd1, 7'd10, 1'b0, 1'b0));
		add_row(OP_UPDATE, 32'd3000, 16'sd500, 16'sd100, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_UPDATE, 32'd6000, 16'sd500, 16'sd100, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_UPDATE, 32'd11000, 16'sd500, 16'sd100, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_UPDATE, 32'd11500, 16'sd100, 16'sd500, 1'b0, 1'b1, 1'b0, '0);
		// difference saturates low: safe
		add_row(OP_UPDATE, 32'd12000, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 1'b1,
			mk_status(PH_DONE, 1'b0, 8'd0, 7'd100, 1'b1, 1'b1));
		add_row(OP_UPDATE, 32'd13000, 16'sd500, 16'sd100, 1'b1, 1'b1, 1'b1,
			mk_status(PH_DONE, 1'b0, 8'd0, 7'd100, 1'b1, 1'b1));
		// restart from complete; difference saturates high
		add_row(OP_START, 32'hFFFF_FF00, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 1'b1,
			mk_status(PH_RUN, 1'b1, 8'd1, 7'd10, 1'b1, 1'b0));
		// one past the timeout, across the clock wrap
		add_row(OP_UPDATE, 32'h0009_26C1, 16'sd500, 16'sd100, 1'b1, 1'b1, 1'b1,
			mk_status(PH_TIMEOUT, 1'b0, 8'd0, 7'd100, 1'b1, 1'b1));
		add_row(OP_START, 32'd5, 16'sd200, 16'sd200, 1'b1, 1'b1, 1'b1,
			mk_status(PH_DONE, 1'b0, 8'd0, 7'd100, 1'b1, 1'b1));
		add_row(OP_STOP, 32'd6, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1,
			mk_status(PH_IDLE, 1'b0, 8'd0, 7'd0, 1'b1, 1'b0));
		add_row(OP_START, 32'd7, 16'sd1000, 16'sd0, 1'b1, 1'b0, 1'b1,
			mk_status(PH_RUN, 1'b1, 8'd1, 7'd10, 1'b1, 1'b0));
		add_row(OP_NOP, 32'd8, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1,
			mk_status(PH_RUN, 1'b1, 8'd1, 7'd10, 1'b1, 1'b0));
		add_row(OP_STOP, 32'd9, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1,
			mk_status(PH_IDLE, 1'b0, 8'd0, 7'd0, 1'b1, 1'b0));
		add_row(OP_START, 32'd20000, 16'sd600, 16'sd0, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_UPDATE, 32'd25000, 16'sd600, 16'sd0, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_UPDATE, 32'd30000, 16'sd600, 16'sd0, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_UPDATE, 32'd35000, 16'sd600, 16'sd0, 1'b1, 1'b1, 1'b0, '0);
		add_row(OP_STOP, 32'd36000, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1,
			mk_status(PH_IDLE, 1'b0, 8'd0, 7'd0, 1'b1, 1'b0));
		foreach (plan[i])
			send_word(plan[i].op, plan[i].now, plan[i].sup, plan[i].ret, plan[i].sv,
				plan[i].rv, plan[i].fixed_on, plan[i].fixed);

		clock_ms = 32'd40000;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == PHASES - 1)
				idle_on = 1'b0;
			configure(ph);
			live_items = 0;
			// climb all the way to cycle saturation once
			if (ph == 2)
				run_sequence(520, 1'b1);
			while (live_items < quota)
				run_sequence($urandom_range(2, 30), 1'b0);
		end
		settle();

		$display("run covered %0d words in %0d register settings; %0d status words checked",
			words_sent, PHASES + 1, results_seen);
		$display("runs complete %0d, timed out %0d, refused starts %0d, top cycle %0d",
			done_seen, timeout_seen, refused_seen, top_cycle);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
src/pps_pkg.sv
src/pps_ctrl.sv
src/pps_dp.sv
src/pulsed_pump_preheat_sequencer.sv
bench/tb_pulsed_pump_preheat_sequencer.sv
